@@ rtl/core/mea_pkg.sv @@
// ----------------------------------------------------------------------------
// mea_pkg
// Shared types and constants of the element-wise modular ALU.
// ----------------------------------------------------------------------------
package mea_pkg;

    // default element width
    localparam int ELEM_WIDTH_DEF = 60;

    // register file of the configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 1'd1;

    // reset value of both moduli
    localparam int MOD_RESET = 2;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SUB    = 2'd1,
        OP_MUL    = 2'd2,
        OP_SWITCH = 2'd3
    } t_op;

endpackage

@@ rtl/core/mea_rem_pipe.sv @@
// ----------------------------------------------------------------------------
// mea_rem_pipe
// Remainder pipeline: one dividend bit per stage, restoring compare and
// subtract against the modulus, sideband carried alongside.
// ----------------------------------------------------------------------------
module mea_rem_pipe
    import mea_pkg::*;
#(
    parameter int W  = ELEM_WIDTH_DEF,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_dvd,
    input  logic [W-1:0]  i_mod,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_valid [W];
    logic [W-1:0]  r_rem   [W];
    logic [W-1:0]  r_dvd   [W];
    logic [SW-1:0] r_side  [W];

    for (genvar j = 0; j < W; j++) begin : g_stage
        logic          v_in;
        logic [W-1:0]  rem_in;
        logic [W-1:0]  dvd_in;
        logic [SW-1:0] side_in;
        logic [W:0]    t;
        logic [W:0]    d;
        logic [W-1:0]  n_rem;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign dvd_in  = i_dvd;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[j-1];
            assign rem_in  = r_rem[j-1];
            assign dvd_in  = r_dvd[j-1];
            assign side_in = r_side[j-1];
        end

        // shift in the next dividend bit, subtract the modulus if it fits
        assign t     = {rem_in, dvd_in[W-1-j]};
        assign d     = t - {1'b0, i_mod};
        assign n_rem = (t >= {1'b0, i_mod}) ? d[W-1:0] : t[W-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else begin
                r_valid[j] <= v_in;
            end
            r_rem[j]  <= n_rem;
            r_dvd[j]  <= dvd_in;
            r_side[j] <= side_in;
        end
    end

    assign o_valid = r_valid[W-1];
    assign o_rem   = r_rem[W-1];
    assign o_side  = r_side[W-1];

endmodule

@@ rtl/core/mea_mul_pipe.sv @@
// ----------------------------------------------------------------------------
// mea_mul_pipe
// Interleaved modular multiplier: one multiplier bit per stage, double and
// add, then fold back below the modulus with one of two subtractions.
// ----------------------------------------------------------------------------
module mea_mul_pipe
    import mea_pkg::*;
#(
    parameter int W  = ELEM_WIDTH_DEF,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [W-1:0]  i_x,
    input  logic [W-1:0]  i_y,
    input  logic [W-1:0]  i_mod,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_prod,
    output logic [SW-1:0] o_side
);

    logic          r_valid [W];
    logic [W-1:0]  r_acc   [W];
    logic [W-1:0]  r_x     [W];
    logic [W-1:0]  r_y     [W];
    logic [SW-1:0] r_side  [W];

    logic [W+1:0] m1;
    logic [W+1:0] m2;

    assign m1 = {2'b00, i_mod};
    assign m2 = {1'b0, i_mod, 1'b0};

    for (genvar j = 0; j < W; j++) begin : g_stage
        logic          v_in;
        logic [W-1:0]  acc_in;
        logic [W-1:0]  x_in;
        logic [W-1:0]  y_in;
        logic [SW-1:0] side_in;
        logic [W+1:0]  s;
        logic [W+1:0]  s1;
        logic [W+1:0]  s2;
        logic [W-1:0]  n_acc;

        if (j == 0) begin : g_first
            assign v_in    = i_valid;
            assign acc_in  = '0;
            assign x_in    = i_x;
            assign y_in    = i_y;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[j-1];
            assign acc_in  = r_acc[j-1];
            assign x_in    = r_x[j-1];
            assign y_in    = r_y[j-1];
            assign side_in = r_side[j-1];
        end

        // double, add the multiplicand on a set bit, reduce below q
        assign s  = {1'b0, acc_in, 1'b0} + (y_in[W-1-j] ? {2'b00, x_in} : '0);
        assign s1 = s - m1;
        assign s2 = s - m2;
        always_comb begin
            if (s >= m2) begin
                n_acc = s2[W-1:0];
            end else if (s >= m1) begin
                n_acc = s1[W-1:0];
            end else begin
                n_acc = s[W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else begin
                r_valid[j] <= v_in;
            end
            r_acc[j]  <= n_acc;
            r_x[j]    <= x_in;
            r_y[j]    <= y_in;
            r_side[j] <= side_in;
        end
    end

    assign o_valid = r_valid[W-1];
    assign o_prod  = r_acc[W-1];
    assign o_side  = r_side[W-1];

endmodule

@@ rtl/core/modular_element_alu.sv @@
// ----------------------------------------------------------------------------
// modular_element_alu
// Element-wise modular ALU: add, subtract, multiply mod q, centered switch
// of a from q to p.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_type, elem_a, elem_b and last_element; the word is
//   taken at the clock edge where start is high and busy is low. busy stays
//   low: the pipeline takes one word every cycle.
//   Each word gives one result word on o_result_value / o_last_out, marked
//   by a one-cycle o_valid strobe, in input order.
//   ELEMENT_WIDTH remainder stages reduce a and b mod q, one stage forms
//   add, subtract and the switch operand, ELEMENT_WIDTH stages run the
//   bit-serial modular multiplier beside the remainder by p, and one stage
//   selects the result.
//   Throughput is one word per cycle, set by the one-bit-per-stage
//   multiplier and remainder pipelines.
//   Write q (index 0) and p (index 1) through i_cfg_we / i_cfg_idx /
//   i_cfg_data only while no word is in flight.
//   Reset clears all valid bits and sets q and p to 2.
//   The receiver cannot stall; results must be taken on the strobe.
// ----------------------------------------------------------------------------
module modular_element_alu
    import mea_pkg::*;
#(
    parameter int ELEMENT_WIDTH = ELEM_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_req_type,
    input  logic [ELEMENT_WIDTH-1:0] i_elem_a,
    input  logic [ELEMENT_WIDTH-1:0] i_elem_b,
    input  logic                     i_last_element,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ELEMENT_WIDTH-1:0] i_cfg_data,
    output logic                     o_valid,
    output logic [ELEMENT_WIDTH-1:0] o_result_value,
    output logic                     o_last_out
);

    localparam int W = ELEMENT_WIDTH;

    logic [W-1:0] r_mod;
    logic [W-1:0] r_tgt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= W'(MOD_RESET);
            r_tgt <= W'(MOD_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MODULUS) begin
                r_mod <= i_cfg_data;
            end else if (i_cfg_idx == CFG_TARGET) begin
                r_tgt <= i_cfg_data;
            end
        end
    end

    assign busy = 1'b0;

    // reduce both operands mod q
    logic         a_valid;
    logic [W-1:0] a_rem;
    logic [1:0]   a_op;
    logic         b_valid;
    logic [W-1:0] b_rem;
    logic         b_last;

    mea_rem_pipe #(.W(W), .SW(2)) u_rem_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_dvd   (i_elem_a),
        .i_mod   (r_mod),
        .i_side  (i_req_type),
        .o_valid (a_valid),
        .o_rem   (a_rem),
        .o_side  (a_op)
    );

    mea_rem_pipe #(.W(W), .SW(1)) u_rem_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_dvd   (i_elem_b),
        .i_mod   (r_mod),
        .i_side  (i_last_element),
        .o_valid (b_valid),
        .o_rem   (b_rem),
        .o_side  (b_last)
    );

    // form add / subtract results and the switch operand
    logic [W:0]   sum;
    logic [W:0]   sum_red;
    logic [W-1:0] n_addsub;
    logic         n_above;
    logic [W-1:0] n_swx;

    assign sum     = {1'b0, a_rem} + {1'b0, b_rem};
    assign sum_red = sum - {1'b0, r_mod};
    assign n_above = a_rem > (r_mod >> 1);
    assign n_swx   = n_above ? (r_mod - a_rem) : a_rem;

    always_comb begin
        case (t_op'(a_op))
            OP_ADD: begin
                n_addsub = (sum >= {1'b0, r_mod}) ? sum_red[W-1:0] : sum[W-1:0];
            end
            OP_SUB: begin
                n_addsub = (a_rem >= b_rem) ? (a_rem - b_rem) : (a_rem + r_mod - b_rem);
            end
            default: begin
                n_addsub = '0;
            end
        endcase
    end

    logic         r_p_valid;
    logic [1:0]   r_p_op;
    logic         r_p_last;
    logic [W-1:0] r_p_addsub;
    logic [W-1:0] r_p_a;
    logic [W-1:0] r_p_b;
    logic [W-1:0] r_p_swx;
    logic         r_p_above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= a_valid & b_valid;
        end
        r_p_op     <= a_op;
        r_p_last   <= b_last;
        r_p_addsub <= n_addsub;
        r_p_a      <= a_rem;
        r_p_b      <= b_rem;
        r_p_swx    <= n_swx;
        r_p_above  <= n_above;
    end

    // multiply mod q beside the remainder by p
    logic         m_valid;
    logic [W-1:0] m_prod;
    logic [W+2:0] m_side;
    logic         s_valid;
    logic [W-1:0] s_rem;
    logic [1:0]   s_side;

    mea_mul_pipe #(.W(W), .SW(W+3)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_valid),
        .i_x     (r_p_a),
        .i_y     (r_p_b),
        .i_mod   (r_mod),
        .i_side  ({r_p_op, r_p_last, r_p_addsub}),
        .o_valid (m_valid),
        .o_prod  (m_prod),
        .o_side  (m_side)
    );

    mea_rem_pipe #(.W(W), .SW(2)) u_rem_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p_valid),
        .i_dvd   (r_p_swx),
        .i_mod   (r_tgt),
        .i_side  ({r_p_above, r_p_a[0]}),
        .o_valid (s_valid),
        .o_rem   (s_rem),
        .o_side  (s_side)
    );

    // select the result word
    logic [1:0]   f_op;
    logic [W-1:0] f_addsub;
    logic         f_above;
    logic         f_par;
    logic [W-1:0] n_res;

    assign f_op     = m_side[W+2:W+1];
    assign f_addsub = m_side[W-1:0];
    assign f_above  = s_side[1];
    assign f_par    = s_side[0];

    always_comb begin
        n_res = '0;
        if (r_mod[W-1:1] != '0) begin
            case (t_op'(f_op))
                OP_ADD, OP_SUB: begin
                    n_res = f_addsub;
                end
                OP_MUL: begin
                    n_res = m_prod;
                end
                OP_SWITCH: begin
                    if (r_tgt[W-1:1] == '0) begin
                        n_res = '0;
                    end else if (r_tgt == W'(2)) begin
                        n_res = {{(W-1){1'b0}}, f_above ^ f_par};
                    end else if (f_above && s_rem != '0) begin
                        n_res = r_tgt - s_rem;
                    end else if (f_above) begin
                        n_res = '0;
                    end else begin
                        n_res = s_rem;
                    end
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end
    end

    logic         r_o_valid;
    logic [W-1:0] r_o_res;
    logic         r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= m_valid & s_valid;
        end
        r_o_res  <= n_res;
        r_o_last <= m_side[W];
    end

    assign o_valid        = r_o_valid;
    assign o_result_value = r_o_res;
    assign o_last_out     = r_o_last;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the element-wise modular ALU. A queue of words
// feeds a clocked driver with random gaps, and a monitor checks every result
// word in order against a predictor of add, subtract, multiply mod q and the
// centered switch to p. It steps through several modulus settings, the
// extremes and the degenerate moduli among them.
// ----------------------------------------------------------------------------
module testbench;
    import mea_pkg::*;

    localparam int W        = ELEM_WIDTH_DEF;
    localparam int LATENCY  = 2 * W + 2;
    localparam int WDOG_MAX = 20 * LATENCY;
    localparam logic [W-1:0] ALL_ONES = '1;

    typedef struct {
        t_op          op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic         last;
    } t_word;

    typedef struct {
        logic [W-1:0] value;
        logic         last;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_req_type;
    logic [W-1:0]         i_elem_a;
    logic [W-1:0]         i_elem_b;
    logic                 i_last_element;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [W-1:0]         i_cfg_data;
    logic                 o_valid;
    logic [W-1:0]         o_result_value;
    logic                 o_last_out;

    t_word        pending_q[$];
    t_result      expected_q[$];
    logic [W-1:0] cur_q;
    logic [W-1:0] cur_p;
    bit           taken;
    bit           quiet;
    int           gap_left;
    int           errors;
    int           words_in;
    int           words_out;
    int           op_count[4];
    int           idle_cycles;

    modular_element_alu i_dut (.*);

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic logic [W-1:0] rnd_elem();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[W-1:0];
    endfunction

    // centered switch of a (already below q) from q to p
    function automatic logic [W-1:0] switch_mod(logic [W-1:0] a, logic [W-1:0] q,
                                                 logic [W-1:0] p);
        logic [W-1:0] d;
        if (p < 2) return '0;
        // parity rule for a target of two
        if (p == 2) begin
            if (a > (q >> 1)) return {{(W-1){1'b0}}, ~a[0]};
            return {{(W-1){1'b0}}, a[0]};
        end
        if (a > (q >> 1)) begin
            d = (q - a) % p;
            return (d == 0) ? '0 : p - d;
        end
        return a % p;
    endfunction

    // expected result word of one input word under the current registers
    function automatic t_result alu_predict(t_word w);
        t_result      res;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [127:0] prod;
        res.last  = w.last;
        res.value = '0;
        if (cur_q >= 2) begin
            a = w.a % cur_q;
            b = w.b % cur_q;
            case (w.op)
                OP_ADD: begin
                    prod = ({68'd0, a} + {68'd0, b}) % {68'd0, cur_q};
                    res.value = prod[W-1:0];
                end
                OP_SUB: res.value = (a >= b) ? a - b : a + (cur_q - b);
                OP_MUL: begin
                    prod = ({68'd0, a} * {68'd0, b}) % {68'd0, cur_q};
                    res.value = prod[W-1:0];
                end
                default: res.value = switch_mod(a, cur_q, cur_p);
            endcase
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        errors++;
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // operand mostly below q, sometimes raw
    function automatic logic [W-1:0] rnd_operand();
        logic [W-1:0] v;
        v = rnd_elem();
        if (cur_q >= 2 && $urandom_range(0, 9) != 0) v = v % cur_q;
        return v;
    endfunction

    task automatic add_word(t_op op, logic [W-1:0] a, logic [W-1:0] b, logic last);
        t_word w;
        w.op   = op;
        w.a    = a;
        w.b    = b;
        w.last = last;
        pending_q.push_back(w);
    endtask

    task automatic add_random(int n);
        for (int k = 0; k < n; k++)
            add_word(t_op'($urandom_range(0, 3)), rnd_operand(), rnd_operand(),
                     $urandom_range(0, 7) == 0);
    endtask

    // drain the pipeline, then write one register while idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W-1:0] data);
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MODULUS) cur_q = data;
        else cur_p = data;
    endtask

    task automatic run_phase(logic [W-1:0] q, logic [W-1:0] p, int n);
        write_reg(CFG_MODULUS, q);
        write_reg(CFG_TARGET, p);
        add_random(n);
    endtask

    // driver: present a word, hold it until taken, insert random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            start <= 1'b1;
        end else begin
            taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_q.size() > 0) begin
                t_word w;
                w = pending_q.pop_front();
                start          <= 1'b1;
                i_req_type     <= w.op;
                i_elem_a       <= w.a;
                i_elem_b       <= w.b;
                i_last_element <= w.last;
                if (!quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 9);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: record accepted words, check result words
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n && start && busy === 1'b0) begin
            t_word w;
            w.op   = t_op'(i_req_type);
            w.a    = i_elem_a;
            w.b    = i_elem_b;
            w.last = i_last_element;
            expected_q.push_back(alu_predict(w));
            op_count[i_req_type]++;
            words_in++;
            taken = 1'b1;
            moved = 1'b1;
        end
        if (i_rst_n && o_valid === 1'b1) begin
            moved = 1'b1;
            words_out++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_result_value, '0);
            end else begin
                t_result e;
                e = expected_q.pop_front();
                if (o_result_value !== e.value)
                    report_mismatch("result_value", o_result_value, e.value);
                if (o_last_out !== e.last)
                    report_mismatch("last_out", {{(W-1){1'b0}}, o_last_out},
                                    {{(W-1){1'b0}}, e.last});
            end
        end
        // watchdog on cycles without progress
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog: no progress for %0d cycles", WDOG_MAX);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [W-1:0] h;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_req_type     = OP_ADD;
        i_elem_a       = '0;
        i_elem_b       = '0;
        i_last_element = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_MODULUS;
        i_cfg_data     = '0;
        cur_q          = MOD_RESET;
        cur_p          = MOD_RESET;
        taken          = 1'b0;
        quiet          = 1'b0;
        gap_left       = 0;
        errors         = 0;
        words_in       = 0;
        words_out      = 0;
        idle_cycles    = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset moduli, random words
        add_random(60);

        // directed: extremes of every operation at the largest q and p
        write_reg(CFG_MODULUS, ALL_ONES);
        write_reg(CFG_TARGET, ALL_ONES);
        h = cur_q >> 1;
        for (int op = 0; op < 4; op++) begin
            add_word(t_op'(op), '0, '0, 1'b0);
            add_word(t_op'(op), cur_q - 1, cur_q - 1, 1'b1);
            add_word(t_op'(op), ALL_ONES, 60'd1, 1'b0);
        end
        add_word(OP_SUB, 60'd1, cur_q - 1, 1'b0);
        add_word(OP_SWITCH, h, rnd_elem(), 1'b0);
        add_word(OP_SWITCH, h + 1, rnd_elem(), 1'b1);
        add_random(120);

        // settings: extremes, degenerate moduli, parity target, random
        run_phase(ALL_ONES, 60'd2, 130);
        run_phase(60'd3, 60'd5, 120);
        run_phase(60'd0, 60'd7, 60);
        run_phase(60'd1, 60'd0, 60);
        run_phase(rnd_elem() | (60'd1 << (W-1)), 60'd1, 130);
        run_phase(rnd_elem(), {44'd0, 16'($urandom)} | 60'd2, 150);
        run_phase({30'd0, 30'($urandom)} | 60'd2, 60'd2, 130);
        run_phase(60'd2, ALL_ONES, 80);
        write_reg(CFG_MODULUS, rnd_elem() | 60'd2);
        write_reg(CFG_TARGET, rnd_elem() >> $urandom_range(0, 56));
        quiet = 1'b1;
        add_random(180);

        // drain, then allow for the pipeline latency
        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("covered %0d words in, %0d results out over eleven modulus settings",
                 words_in, words_out);
        $display("ops: add %0d, sub %0d, mul %0d, switch %0d, mismatches %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3], errors);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
